// File: rtl/core/lmbr_pkg.sv
// Shared types, constants and register codes of the level-meter bar renderer.
package lmbr_pkg;

  localparam int DISPLAY_WIDTH_DEF = 128;
  localparam int MAX_PAGES_DEF     = 8;
  localparam int RESULT_LIMIT      = 8;
  localparam int QUEUE_DEPTH       = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_PAGE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAR_PAGES    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAR_X_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BAR_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BAR_SPACING  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_PEAKS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_BASES   = 3'd6;

  typedef struct packed {
    logic [2:0] first_page;
    logic [3:0] bar_pages;
    logic [6:0] bar_x_offset;
    logic [6:0] bar_width;
    logic [6:0] bar_spacing;
    logic       draw_peaks;
    logic       draw_bases;
  } cfg_t;

  // One bar, classified and ready to be walked page by page.
  typedef struct packed {
    logic [9:0] bottom_addr;
    logic [2:0] last_k;
    logic [6:0] level;
    logic [6:0] peak;
    logic       peak_en;
  } desc_t;

endpackage

// File: rtl/core/lmbr_front.sv
// Front end: accepts bar items, saturates level and peak, applies the base pixel, computes the bottom-page address.
module lmbr_front #(
  parameter int DISPLAY_WIDTH = lmbr_pkg::DISPLAY_WIDTH_DEF,
  parameter int MAX_PAGES     = lmbr_pkg::MAX_PAGES_DEF
) (
  input  lmbr_pkg::cfg_t                    cfg,
  input  logic [lmbr_pkg::IN_DATA_W-1:0]    in_tdata,
  output lmbr_pkg::desc_t                   desc
);

  localparam int PAGE_CAP = (MAX_PAGES < lmbr_pkg::RESULT_LIMIT) ?
                            MAX_PAGES : lmbr_pkg::RESULT_LIMIT;

  logic [3:0]  channel;
  logic [6:0]  level_in;
  logic [6:0]  peak_in;
  logic [3:0]  pages;
  logic [6:0]  height;
  logic [6:0]  level_sat;
  logic [6:0]  peak_sat;
  logic [7:0]  stride;
  logic [11:0] col_off;
  logic [4:0]  bottom_row;
  logic [15:0] row_addr;
  logic [15:0] addr_sum;

  assign channel  = in_tdata[3:0];
  assign level_in = in_tdata[10:4];
  assign peak_in  = in_tdata[17:11];

  always_comb begin
    pages = (cfg.bar_pages == 4'd0) ? 4'd1 : cfg.bar_pages;
    if ({1'b0, pages} > 5'(PAGE_CAP)) begin
      pages = 4'(PAGE_CAP);
    end
    height = {pages, 3'b000};

    level_sat = (level_in > height) ? height : level_in;
    if (cfg.draw_bases && (level_sat == 7'd0)) begin
      level_sat = 7'd1;
    end
    peak_sat = (peak_in > height) ? height : peak_in;

    stride     = {1'b0, cfg.bar_width} + {1'b0, cfg.bar_spacing};
    col_off    = channel * stride;
    bottom_row = {2'b00, cfg.first_page} + {1'b0, pages} - 5'd1;
    row_addr   = 16'(bottom_row * 16'(DISPLAY_WIDTH));
    addr_sum   = row_addr + {9'd0, cfg.bar_x_offset} + {4'd0, col_off};

    desc.bottom_addr = addr_sum[9:0];
    desc.last_k      = 3'(pages - 4'd1);
    desc.level       = level_sat;
    desc.peak        = peak_sat;
    desc.peak_en     = cfg.draw_peaks && (peak_sat != 7'd0);
  end

endmodule

// File: rtl/core/lmbr_fifo.sv
// Short descriptor queue between front and back.
module lmbr_fifo #(
  parameter int DEPTH = lmbr_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lmbr_pkg::desc_t push_data,
  input  logic            pop,
  output lmbr_pkg::desc_t head,
  output logic            full,
  output logic            empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lmbr_pkg::desc_t slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/core/lmbr_back.sv
// Back end: walks the head bar page by page and drives the registered write output.
module lmbr_back #(
  parameter int DISPLAY_WIDTH = lmbr_pkg::DISPLAY_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lmbr_pkg::desc_t                 head,
  input  logic                            empty,
  output logic                            pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lmbr_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tlast
);

  localparam logic [9:0] DW_MOD = 10'(DISPLAY_WIDTH);

  logic [2:0] k_r, k_nxt;
  logic       valid_r, valid_nxt;
  logic [9:0] addr_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       emit;

  logic [3:0] full_pg;
  logic [2:0] rem;
  logic [3:0] ppage;
  logic [2:0] prem;
  logic [7:0] page_byte;
  logic [9:0] page_addr;
  logic       is_last;

  assign emit    = !empty && (!valid_r || out_tready);
  assign is_last = (k_r == head.last_k);
  assign pop     = emit && is_last;

  always_comb begin
    full_pg = head.level[6:3];
    rem     = head.level[2:0];
    ppage   = head.peak[6:3];
    prem    = head.peak[2:0];

    if ({1'b0, k_r} < full_pg) begin
      page_byte = 8'hFF;
    end else if (({1'b0, k_r} == full_pg) && (rem != 3'd0)) begin
      page_byte = ~(8'hFF >> rem);
    end else begin
      page_byte = 8'h00;
    end

    // Peak marker; a peak on a page boundary marks bit 0 of the page below.
    if (head.peak_en) begin
      if (prem != 3'd0) begin
        if ({1'b0, k_r} == ppage) begin
          page_byte = page_byte | (8'h01 << (3'd0 - prem));
        end
      end else if (({1'b0, k_r} + 4'd1) == ppage) begin
        page_byte = page_byte | 8'h01;
      end
    end

    page_addr = head.bottom_addr - 10'({7'd0, k_r} * DW_MOD);

    k_nxt     = k_r;
    valid_nxt = valid_r;
    if (emit) begin
      k_nxt     = is_last ? 3'd0 : k_r + 3'd1;
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= 3'd0;
      valid_r <= 1'b0;
    end else begin
      k_r     <= k_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      addr_r <= page_addr;
      byte_r <= page_byte;
      last_r <= is_last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {6'd0, byte_r, addr_r};
  assign out_tlast  = last_r;

endmodule

// File: rtl/core/level_meter_bar_page_renderer.sv
// Top level of the level-meter bar renderer: config registers, front, queue and back.
//
// Each input item describes one vertical meter bar (channel, level and peak in
// pixels) and produces one framebuffer write per page of the bar, bottom page
// first, the top page flagged with out_tlast. Each write carries the byte
// address of the bar's first column in that page and the page byte (bit 7 is
// the bottom pixel); copying it across the bar's columns is up to the memory
// writer. The front end classifies an item in the cycle it is accepted and
// queues it; the back end emits one page write per cycle, while the receiver
// keeps taking them, from a registered output; a bar of n pages (n = bar_pages
// clamped to 1..min(MAX_PAGES, 8)) takes n writes, and consecutive bars follow
// with no gap. The rate of items is set by the single page-write output; the
// queue absorbs up to two pending bars so input and output stall independently.
// An accepted item is stored in a queue slot before its first page write is
// registered at the output. Write configuration only while no bar is in flight.
module level_meter_bar_page_renderer #(
  parameter int DISPLAY_WIDTH = lmbr_pkg::DISPLAY_WIDTH_DEF,
  parameter int MAX_PAGES     = lmbr_pkg::MAX_PAGES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [lmbr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lmbr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // input items
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [3:0] channel, [10:4] level_pixels, [17:11] peak_pixels, [23:18] zero
  input  logic [lmbr_pkg::IN_DATA_W-1:0]   in_tdata,
  // result items
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [9:0] address, [17:10] page_byte, [23:18] zero
  output logic [lmbr_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                             out_tlast
);

  lmbr_pkg::cfg_t  cfg_r;
  lmbr_pkg::desc_t front_desc;
  lmbr_pkg::desc_t head;
  logic            q_full;
  logic            q_empty;
  logic            q_pop;
  logic            push;

  // Configuration registers; out-of-range indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_page   <= 3'd0;
      cfg_r.bar_pages    <= 4'd6;
      cfg_r.bar_x_offset <= 7'd2;
      cfg_r.bar_width    <= 7'd12;
      cfg_r.bar_spacing  <= 7'd2;
      cfg_r.draw_peaks   <= 1'b1;
      cfg_r.draw_bases   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        lmbr_pkg::REG_FIRST_PAGE:   cfg_r.first_page   <= cfg_wdata[2:0];
        lmbr_pkg::REG_BAR_PAGES:    cfg_r.bar_pages    <= cfg_wdata[3:0];
        lmbr_pkg::REG_BAR_X_OFFSET: cfg_r.bar_x_offset <= cfg_wdata[6:0];
        lmbr_pkg::REG_BAR_WIDTH:    cfg_r.bar_width    <= cfg_wdata[6:0];
        lmbr_pkg::REG_BAR_SPACING:  cfg_r.bar_spacing  <= cfg_wdata[6:0];
        lmbr_pkg::REG_DRAW_PEAKS:   cfg_r.draw_peaks   <= cfg_wdata[0];
        lmbr_pkg::REG_DRAW_BASES:   cfg_r.draw_bases   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Accept whenever the queue has room.
  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;

  lmbr_front #(
    .DISPLAY_WIDTH (DISPLAY_WIDTH),
    .MAX_PAGES     (MAX_PAGES)
  ) u_front (
    .cfg      (cfg_r),
    .in_tdata (in_tdata),
    .desc     (front_desc)
  );

  lmbr_fifo #(
    .DEPTH (lmbr_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_desc),
    .pop       (q_pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  lmbr_back #(
    .DISPLAY_WIDTH (DISPLAY_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (q_empty),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// File: tb/tb_level_meter_bar_page_renderer.sv
// Self-checking testbench for the level-meter bar page renderer.
module tb_level_meter_bar_page_renderer;
  timeunit 1ns;
  timeprecision 1ps;

  // Generous ceiling: several times the slowest legal run of this stimulus.
  localparam longint RUN_LIMIT_NS = 64'd5_000_000;
  localparam int     SETTLE_CYCLES = 4;
  localparam int     MAX_PRINTED = 100;

  // One framebuffer write as the block should emit it.
  typedef struct packed {
    logic [9:0] address;
    logic [7:0] page_byte;
    logic       last;
  } page_write_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [lmbr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [lmbr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  // [3:0] channel, [10:4] level_pixels, [17:11] peak_pixels, [23:18] zero
  logic [lmbr_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  // [9:0] address, [17:10] page_byte, [23:18] zero
  logic [lmbr_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            out_tlast;

  // Shadow copy of the block's registers, kept in step with every write.
  lmbr_pkg::cfg_t meter_cfg;
  page_write_t    pending_writes[$];
  page_write_t    oldest_write;
  int unsigned    mismatch_count = 0;

  // Idling knobs, flipped per phase; rx_hold counts receiver stall cycles.
  bit in_gaps_on = 1'b1;
  bit rx_stalls_on = 1'b1;
  int rx_hold = 0;

  level_meter_bar_page_renderer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Gap length in cycles: mostly none, often a few, now and then a long one.
  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_count < MAX_PRINTED)
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Work out every page write one bar produces under the current registers
  // and queue them bottom page first.
  function automatic void render_bar(input logic [3:0] channel, input logic [6:0] level_in,
                                     input logic [6:0] peak_in);
    int unsigned pages, height, level, peak, full, rem, ppage, prem, column, row, addr;
    logic [7:0] page_px [lmbr_pkg::RESULT_LIMIT];
    page_write_t wr;
    // Clamp the page count: zero counts as one, anything above the limit as the limit.
    pages = 32'(meter_cfg.bar_pages);
    if (pages == 0) pages = 1;
    if (pages > lmbr_pkg::MAX_PAGES_DEF) pages = lmbr_pkg::MAX_PAGES_DEF;
    if (pages > lmbr_pkg::RESULT_LIMIT) pages = lmbr_pkg::RESULT_LIMIT;
    height = pages * 8;
    level = 32'(level_in);
    peak = 32'(peak_in);
    if (level > height) level = height;
    if (peak > height) peak = height;
    // A zero level still shows one pixel when bases are on.
    if (meter_cfg.draw_bases && level == 0) level = 1;
    full = level / 8;
    rem = level % 8;
    for (int k = 0; k < lmbr_pkg::RESULT_LIMIT; k++)
      page_px[k] = (k < full) ? 8'hFF : 8'h00;
    // Partial page fills from bit 7 (bottom pixel) upward.
    if (rem != 0 && full < pages) page_px[full] = 8'hFF << (8 - rem);
    if (meter_cfg.draw_peaks && peak != 0) begin
      ppage = peak / 8;
      prem = peak % 8;
      // A peak on a page boundary lands on bit 0 of the page below it.
      if (prem != 0) begin
        if (ppage < pages) page_px[ppage] |= 8'h01 << (8 - prem);
      end else if (ppage >= 1 && ppage - 1 < pages) begin
        page_px[ppage - 1] |= 8'h01;
      end
    end
    column = meter_cfg.bar_x_offset + channel * (meter_cfg.bar_width + meter_cfg.bar_spacing);
    for (int k = 0; k < pages; k++) begin
      row = meter_cfg.first_page + (pages - 1 - k);
      addr = row * lmbr_pkg::DISPLAY_WIDTH_DEF + column;
      wr.address = addr[9:0];
      wr.page_byte = page_px[k];
      wr.last = (k == pages - 1);
      pending_writes.push_back(wr);
    end
  endfunction

  // Offer one bar and hold it until the block takes it; tvalid stays high
  // afterwards so back-to-back items need no extra edge.
  task automatic send_bar(input logic [3:0] channel, input logic [6:0] level,
                          input logic [6:0] peak);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, peak, level, channel};
    do @(posedge clk); while (in_tready !== 1'b1);
    render_bar(channel, level, peak);
  endtask

  // Drop tvalid for a random number of cycles when input gaps are enabled.
  task automatic pace_input();
    int n;
    n = in_gaps_on ? idle_len() : 0;
    if (n > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // Hold until every queued write has come out, then let the block go quiet.
  task automatic wait_drained();
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [lmbr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lmbr_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      lmbr_pkg::REG_FIRST_PAGE:   meter_cfg.first_page = data[2:0];
      lmbr_pkg::REG_BAR_PAGES:    meter_cfg.bar_pages = data[3:0];
      lmbr_pkg::REG_BAR_X_OFFSET: meter_cfg.bar_x_offset = data;
      lmbr_pkg::REG_BAR_WIDTH:    meter_cfg.bar_width = data;
      lmbr_pkg::REG_BAR_SPACING:  meter_cfg.bar_spacing = data;
      lmbr_pkg::REG_DRAW_PEAKS:   meter_cfg.draw_peaks = data[0];
      lmbr_pkg::REG_DRAW_BASES:   meter_cfg.draw_bases = data[0];
      default: ;
    endcase
  endtask

  // Write all seven registers; with noisy set, fill the unused upper bits
  // of the narrow ones with junk the block must ignore.
  task automatic set_config(input lmbr_pkg::cfg_t c, input bit noisy);
    logic [6:0] junk;
    junk = noisy ? 7'($urandom) : 7'd0;
    drop_valid();
    wait_drained();
    write_reg(lmbr_pkg::REG_FIRST_PAGE, {junk[6:3], c.first_page});
    write_reg(lmbr_pkg::REG_BAR_PAGES, {junk[6:4], c.bar_pages});
    write_reg(lmbr_pkg::REG_BAR_X_OFFSET, c.bar_x_offset);
    write_reg(lmbr_pkg::REG_BAR_WIDTH, c.bar_width);
    write_reg(lmbr_pkg::REG_BAR_SPACING, c.bar_spacing);
    write_reg(lmbr_pkg::REG_DRAW_PEAKS, {junk[6:1], c.draw_peaks});
    write_reg(lmbr_pkg::REG_DRAW_BASES, {junk[6:1], c.draw_bases});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic lmbr_pkg::cfg_t reset_cfg();
    lmbr_pkg::cfg_t c;
    c.first_page = 3'd0;
    c.bar_pages = 4'd6;
    c.bar_x_offset = 7'd2;
    c.bar_width = 7'd12;
    c.bar_spacing = 7'd2;
    c.draw_peaks = 1'b1;
    c.draw_bases = 1'b0;
    return c;
  endfunction

  // Heights biased toward the interesting range: page boundaries, zero, saturation.
  function automatic logic [6:0] pick_height();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 7'($urandom_range(0, 64));
      6:                return 7'(8 * $urandom_range(0, 8));
      7:                return 7'd0;
      default:          return 7'($urandom_range(0, 127));
    endcase
  endfunction

  task automatic run_reset();
    meter_cfg = reset_cfg();
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  endtask

  // Reset registers: six pages, peaks on; walk the level and peak corners.
  task automatic test_reset_defaults();
    send_bar(4'd0, 7'd0, 7'd0);
    send_bar(4'd15, 7'd48, 7'd0);
    send_bar(4'd1, 7'd64, 7'd0);     // level above the bar
    send_bar(4'd2, 7'd127, 7'd127);  // both fields at their widest
    send_bar(4'd3, 7'd5, 7'd3);      // partial page with peak on the same page
    send_bar(4'd4, 7'd20, 7'd8);     // peak on a page boundary
    send_bar(4'd5, 7'd13, 7'd48);    // peak exactly at the bar top
    send_bar(4'd6, 7'd0, 7'd1);
    send_bar(4'd7, 7'd47, 7'd46);
  endtask

  // Bases on: a zero level must still show one pixel; then mix with peaks.
  task automatic test_bases_and_peaks();
    lmbr_pkg::cfg_t c;
    c = reset_cfg();
    c.draw_bases = 1'b1;
    c.draw_peaks = 1'b0;
    set_config(c, 1'b0);
    send_bar(4'd0, 7'd0, 7'd0);
    send_bar(4'd1, 7'd0, 7'd30);     // peak suppressed
    send_bar(4'd2, 7'd9, 7'd9);
    c.draw_peaks = 1'b1;
    set_config(c, 1'b0);
    send_bar(4'd3, 7'd0, 7'd1);      // base and peak share the bottom pixel
    send_bar(4'd4, 7'd0, 7'd0);
  endtask

  // Page-count and address extremes: zero pages, too many pages, address wrap.
  task automatic test_page_extremes();
    lmbr_pkg::cfg_t c;
    c = reset_cfg();
    c.first_page = 3'd7;
    c.bar_pages = 4'd0;
    set_config(c, 1'b0);
    send_bar(4'd0, 7'd8, 7'd8);
    send_bar(4'd1, 7'd100, 7'd5);
    send_bar(4'd2, 7'd3, 7'd0);
    c.bar_pages = 4'd15;
    c.bar_x_offset = 7'd127;
    c.bar_width = 7'd127;
    c.bar_spacing = 7'd127;
    c.draw_bases = 1'b1;
    set_config(c, 1'b0);
    send_bar(4'd15, 7'd127, 7'd64);
    send_bar(4'd15, 7'd64, 7'd127);
    send_bar(4'd0, 7'd33, 7'd57);
  endtask

  // Stall the receiver for a long stretch while the sender keeps pushing
  // eight-page bars, so the queue fills and in_tready drops; then drain.
  task automatic test_backpressure();
    lmbr_pkg::cfg_t c;
    c = reset_cfg();
    c.bar_pages = 4'd8;
    set_config(c, 1'b0);
    in_gaps_on = 1'b0;
    rx_hold = 80;
    for (int i = 0; i < 8; i++)
      send_bar(4'($urandom), pick_height(), pick_height());
    drop_valid();
    wait_drained();
    in_gaps_on = 1'b1;
  endtask

  // Random bars across several register settings, extremes first.
  task automatic test_random_bars();
    lmbr_pkg::cfg_t c;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: c = '{first_page: 3'd0, bar_pages: 4'd1, bar_x_offset: 7'd0, bar_width: 7'd1,
                 bar_spacing: 7'd0, draw_peaks: 1'b0, draw_bases: 1'b0};
        1: c = '{first_page: 3'd7, bar_pages: 4'd15, bar_x_offset: 7'd127, bar_width: 7'd127,
                 bar_spacing: 7'd127, draw_peaks: 1'b1, draw_bases: 1'b1};
        default: c = lmbr_pkg::cfg_t'(30'($urandom));
      endcase
      set_config(c, phase >= 2);
      // One phase runs flat out on both sides.
      in_gaps_on = (phase != 2);
      rx_stalls_on = (phase != 2);
      for (int i = 0; i < 22; i++) begin
        send_bar(4'($urandom), pick_height(), pick_height());
        pace_input();
        // Pause the sender mid-phase until everything queued has come out.
        if (phase == 1 && i == 10) begin
          drop_valid();
          wait_drained();
        end
      end
    end
    in_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // Receiver: count down any requested hold, otherwise stall at random.
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else if (rx_stalls_on && $urandom_range(0, 99) < 30) begin
      out_tready <= 1'b0;
      rx_hold = idle_len();
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each accepted write with the oldest outstanding expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (pending_writes.size() == 0) begin
        report_mismatch("write with nothing expected", 32'(out_tdata), 32'd0);
      end else begin
        oldest_write = pending_writes.pop_front();
        if (out_tdata[9:0] !== oldest_write.address)
          report_mismatch("address", 32'(out_tdata[9:0]), 32'(oldest_write.address));
        if (out_tdata[17:10] !== oldest_write.page_byte)
          report_mismatch("page_byte", 32'(out_tdata[17:10]), 32'(oldest_write.page_byte));
        if (out_tlast !== oldest_write.last)
          report_mismatch("last", 32'(out_tlast), 32'(oldest_write.last));
      end
    end
  end

  initial begin
    run_reset();
    test_reset_defaults();
    test_bases_and_peaks();
    test_page_extremes();
    test_backpressure();
    test_random_bars();
    drop_valid();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("tb_level_meter_bar_page_renderer: PASS");
    end else begin
      $display("tb_level_meter_bar_page_renderer: FAIL");
    end
    $finish;
  end

  // Hang guard.
  initial begin
    #(RUN_LIMIT_NS * 1ns);
    $display("tb_level_meter_bar_page_renderer: FAIL");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/lmbr_pkg.sv
rtl/core/lmbr_front.sv
rtl/core/lmbr_fifo.sv
rtl/core/lmbr_back.sv
rtl/core/level_meter_bar_page_renderer.sv
tb/tb_level_meter_bar_page_renderer.sv
